### rtl/yhsv_pkg.sv
// ---------------------------------------------------------------------------
// YIQ hue/saturation/value transform package
// Shared constants, matrix coefficients and the sine table builder.
// ---------------------------------------------------------------------------
`default_nettype none

package yhsv_pkg;

  // Default parameter values.
  localparam int HUE_BITS_DEF       = 10;
  localparam int TRIG_FRAC_BITS_DEF = 14;

  // Width of the hue field on the input channel.
  localparam int HUE_IN_BITS = 10;

  // Pipeline depth: stages in each part and in total.
  localparam int MIX_STAGES  = 5;
  localparam int NORM_STAGES = 3;
  localparam int PIPE_STAGES = MIX_STAGES + NORM_STAGES;

  // pi/2 in Q30.
  localparam longint PI_HALF_Q30 = 64'sd1686629713;

  // Per-color weighted sums of the pixel, signed width.
  localparam int SUM_BITS  = 21;
  // Luma-weighted sum of the pixel, unsigned width.
  localparam int LUMA_BITS = 18;
  // Low part of the rotated sum that is multiplied separately.
  localparam int E_LO_BITS = 20;
  // Accumulator width above the trig fraction bits.
  localparam int ACC_HEAD  = 43;

  // Channel normalization: divide by 1000 through a reciprocal.
  localparam int CHAN_MAX    = 255;
  localparam int CHAN_DIV    = 1000;
  localparam int CHAN_LIMIT  = 256000;
  localparam int X_BITS      = 18;
  localparam int DIV_SHIFT   = 28;
  localparam int DIV_MULT    = 268435;
  localparam int DIV_M_BITS  = 19;

  // Matrix coefficients in thousandths: [channel][input color].
  localparam int COEF_V [3]    = '{299, 587, 114};
  localparam int COEF_U [3][3] = '{'{ 701, -587, -114},
                                   '{-299,  413, -114},
                                   '{-300, -588,  886}};
  localparam int COEF_W [3][3] = '{'{ 168,  330, -497},
                                   '{-328,   35,  292},
                                   '{1250, -1050, -203}};

  // First-quadrant sine magnitude for offset r of a quarter turn of
  // 2^(hb-2) steps, Taylor series to x^17 in Q30, rounded to fb bits.
  function automatic longint quarter_sin(input longint r, input int hb, input int fb);
    longint x;
    longint x2;
    longint term;
    longint sum;
    x    = (PI_HALF_Q30 * r) >>> (hb - 2);
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >>> 30) / 64'sd6;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 64'sd20;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 64'sd42;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 64'sd72;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 64'sd110;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 64'sd156;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 64'sd210;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 64'sd272;
    sum  = sum + term;
    if (sum < 0) begin
      sum = 0;
    end
    return (sum + (64'sd1 <<< (29 - fb))) >>> (30 - fb);
  endfunction

endpackage

`default_nettype wire

### rtl/yhsv_trig.sv
// ---------------------------------------------------------------------------
// YIQ hue transform: sine and cosine lookup
// Maps the hue to the table index and reads a quarter-wave sine table.
// ---------------------------------------------------------------------------
`default_nettype none

module yhsv_trig
  import yhsv_pkg::*;
#(
  parameter int HUE_BITS       = HUE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [HUE_IN_BITS-1:0]    hue_turn,
  output logic      [TRIG_FRAC_BITS:0]   sin_mag_r,
  output logic                           sin_neg_r,
  output logic      [TRIG_FRAC_BITS:0]   cos_mag_r,
  output logic                           cos_neg_r
);

  localparam int QB      = HUE_BITS - 2;
  localparam int QUARTER = 1 << QB;
  localparam int AW      = HUE_BITS - 1;
  localparam int MW      = TRIG_FRAC_BITS + 1;

  logic [MW-1:0]       qtab [QUARTER+1];
  logic [HUE_BITS-1:0] k;
  logic [HUE_BITS-1:0] kc;
  logic [AW-1:0]       sin_addr;
  logic [AW-1:0]       cos_addr;

  // Quarter-wave sine table, built at elaboration.
  for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
    assign qtab[g] = MW'(quarter_sin(longint'(g), HUE_BITS, TRIG_FRAC_BITS));
  end

  // Bring the hue field to the table resolution.
  if (HUE_BITS >= HUE_IN_BITS) begin : g_up
    assign k = HUE_BITS'(hue_turn) << (HUE_BITS - HUE_IN_BITS);
  end else begin : g_down
    assign k = hue_turn[HUE_IN_BITS-1 -: HUE_BITS];
  end

  // Cosine is the sine a quarter turn later.
  assign kc = k + HUE_BITS'(QUARTER);

  // Fold each index into the first quadrant; odd quadrants run backward.
  always_comb begin
    if (k[QB]) begin
      sin_addr = AW'(QUARTER) - AW'(k[QB-1:0]);
    end else begin
      sin_addr = AW'(k[QB-1:0]);
    end
    if (kc[QB]) begin
      cos_addr = AW'(QUARTER) - AW'(kc[QB-1:0]);
    end else begin
      cos_addr = AW'(kc[QB-1:0]);
    end
  end

  // Registered table read; the lower half turn is negative.
  always_ff @(posedge clk) begin
    if (en) begin
      sin_mag_r <= qtab[sin_addr];
      sin_neg_r <= k[HUE_BITS-1];
      cos_mag_r <= qtab[cos_addr];
      cos_neg_r <= kc[HUE_BITS-1];
    end
  end

endmodule

`default_nettype wire

### rtl/yhsv_mix.sv
// ---------------------------------------------------------------------------
// YIQ hue transform: matrix datapath
// Forms the exact channel sums V*P + V*S*(cos*Qu + sin*Qw) in five stages.
// ---------------------------------------------------------------------------
`default_nettype none

module yhsv_mix
  import yhsv_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic        [MIX_STAGES-1:0]         en,
  input  wire logic        [8:0]                    saturation,
  input  wire logic        [8:0]                    brightness,
  input  wire logic        [7:0]                    red,
  input  wire logic        [7:0]                    green,
  input  wire logic        [7:0]                    blue,
  input  wire logic        [TRIG_FRAC_BITS:0]       sin_mag,
  input  wire logic                                 sin_neg,
  input  wire logic        [TRIG_FRAC_BITS:0]       cos_mag,
  input  wire logic                                 cos_neg,
  output logic signed      [TRIG_FRAC_BITS+ACC_HEAD-1:0] acc_r [3]
);

  localparam int CW  = TRIG_FRAC_BITS + 2;
  localparam int PW  = CW + SUM_BITS;
  localparam int EW  = PW + 1;
  localparam int HW  = EW - E_LO_BITS;
  localparam int PHW = HW + 19;
  localparam int PLW = E_LO_BITS + 18;
  localparam int ACW = TRIG_FRAC_BITS + ACC_HEAD;
  localparam int VPW = 9 + LUMA_BITS;

  // Stage 0 registers.
  logic        [8:0]            v_r;
  logic        [8:0]            s_r;
  logic        [LUMA_BITS-1:0]  p_r;
  logic        [LUMA_BITS-1:0]  p_nxt;
  logic signed [SUM_BITS-1:0]   su_r  [3];
  logic signed [SUM_BITS-1:0]   su_nxt [3];
  logic signed [SUM_BITS-1:0]   sw_r  [3];
  logic signed [SUM_BITS-1:0]   sw_nxt [3];

  // Stage 1 registers.
  logic signed [CW-1:0]         cos_s;
  logic signed [CW-1:0]         sin_s;
  logic        [17:0]           vs1_r;
  logic        [VPW-1:0]        vp1_r;
  logic signed [PW-1:0]         cq_r [3];
  logic signed [PW-1:0]         sr_r [3];

  // Stage 2 registers.
  logic        [17:0]           vs2_r;
  logic        [VPW-1:0]        vp2_r;
  logic signed [EW-1:0]         e_r [3];

  // Stage 3 registers.
  logic        [VPW-1:0]        vp3_r;
  logic signed [PHW-1:0]        ph_r [3];
  logic        [PLW-1:0]        pl_r [3];

  // Stage 4 next value.
  logic signed [ACW-1:0]        acc_nxt [3];

  // Weighted pixel sums; the luma weights are shared by all channels.
  always_comb begin
    p_nxt = LUMA_BITS'(COEF_V[0] * int'(red) + COEF_V[1] * int'(green)
                       + COEF_V[2] * int'(blue));
    for (int c = 0; c < 3; c++) begin
      su_nxt[c] = SUM_BITS'(COEF_U[c][0] * int'(red) + COEF_U[c][1] * int'(green)
                            + COEF_U[c][2] * int'(blue));
      sw_nxt[c] = SUM_BITS'(COEF_W[c][0] * int'(red) + COEF_W[c][1] * int'(green)
                            + COEF_W[c][2] * int'(blue));
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      v_r  <= brightness;
      s_r  <= saturation;
      p_r  <= p_nxt;
      su_r <= su_nxt;
      sw_r <= sw_nxt;
    end
  end

  // Signed sine and cosine from the table magnitudes.
  always_comb begin
    cos_s = signed'({1'b0, cos_mag});
    if (cos_neg) begin
      cos_s = -cos_s;
    end
    sin_s = signed'({1'b0, sin_mag});
    if (sin_neg) begin
      sin_s = -sin_s;
    end
  end

  // First multiply stage: gains and trig times the pixel sums.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      vs1_r <= 18'(v_r) * 18'(s_r);
      vp1_r <= VPW'(v_r) * VPW'(p_r);
      for (int c = 0; c < 3; c++) begin
        cq_r[c] <= PW'(cos_s) * PW'(su_r[c]);
        sr_r[c] <= PW'(sin_s) * PW'(sw_r[c]);
      end
    end
  end

  // Rotated chroma sum per channel.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      vs2_r <= vs1_r;
      vp2_r <= vp1_r;
      for (int c = 0; c < 3; c++) begin
        e_r[c] <= EW'(cq_r[c]) + EW'(sr_r[c]);
      end
    end
  end

  // Second multiply stage: V*S times the rotated sum, split in two halves.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      vp3_r <= vp2_r;
      for (int c = 0; c < 3; c++) begin
        ph_r[c] <= PHW'(signed'({1'b0, vs2_r})) * PHW'(signed'(e_r[c][EW-1:E_LO_BITS]));
        pl_r[c] <= PLW'(vs2_r) * PLW'(e_r[c][E_LO_BITS-1:0]);
      end
    end
  end

  // Exact channel sum, all terms aligned to the common fraction point.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_nxt[c] = signed'((ACW'(vp3_r) << (8 + TRIG_FRAC_BITS))
                           + (ACW'(ph_r[c]) << E_LO_BITS) + ACW'(pl_r[c]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/yhsv_norm.sv
// ---------------------------------------------------------------------------
// YIQ hue transform: channel normalization
// Scales one channel sum down, divides by 1000 and clamps to 0..255.
// ---------------------------------------------------------------------------
`default_nettype none

module yhsv_norm
  import yhsv_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  wire logic                                      clk,
  input  wire logic        [NORM_STAGES-1:0]             en,
  input  wire logic signed [TRIG_FRAC_BITS+ACC_HEAD-1:0] acc,
  output logic             [7:0]                         chan_r
);

  localparam int ACW = TRIG_FRAC_BITS + ACC_HEAD;
  localparam int SH  = 16 + TRIG_FRAC_BITS;
  localparam int XW  = ACW - SH;
  localparam int DPW = X_BITS + DIV_M_BITS;

  logic [XW-1:0]     x_full;
  logic              neg1_r;
  logic              sat1_r;
  logic [X_BITS-1:0] x1_r;
  logic              neg2_r;
  logic              sat2_r;
  logic [X_BITS-1:0] x2_r;
  logic [7:0]        q0_r;
  logic [DPW-1:0]    prod;
  logic [X_BITS-1:0] rem;
  logic [7:0]        chan_nxt;

  // Drop the fraction bits and flag the out-of-range cases.
  assign x_full = acc[ACW-1:SH];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg1_r <= acc[ACW-1];
      sat1_r <= !acc[ACW-1] && (x_full >= XW'(CHAN_LIMIT));
      x1_r   <= x_full[X_BITS-1:0];
    end
  end

  // Reciprocal multiply gives the quotient or one less.
  assign prod = DPW'(x1_r) * DPW'(DIV_MULT);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      neg2_r <= neg1_r;
      sat2_r <= sat1_r;
      x2_r   <= x1_r;
      q0_r   <= prod[DIV_SHIFT +: 8];
    end
  end

  // Correct the quotient by one if the remainder is still a full divisor.
  always_comb begin
    rem = x2_r - (X_BITS'(q0_r) * X_BITS'(CHAN_DIV));
    if (neg2_r) begin
      chan_nxt = 8'd0;
    end else if (sat2_r) begin
      chan_nxt = 8'(CHAN_MAX);
    end else if (rem >= X_BITS'(CHAN_DIV)) begin
      chan_nxt = q0_r + 8'd1;
    end else begin
      chan_nxt = q0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      chan_r <= chan_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/yiq_hue_saturation_value_transform_unit.sv
// ---------------------------------------------------------------------------
// YIQ hue/saturation/value transform unit
// Rotates the hue of an RGB pixel in YIQ space and scales its saturation
// and value, giving the clamped RGB result.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one pixel with its hue shift
//   (1024 steps per turn), saturation gain and value gain, both Q1.8.
//   Output channel (out_valid/out_ready) carries the transformed pixel.
//   Each input transaction gives exactly one output transaction, in order.
// Throughput and stages:
//   While the output is not stalled, the pipeline takes one pixel every
//   cycle over eight stages: the first reads the sine table beside the
//   pixel weighting, four more finish the matrix datapath with its two
//   multiply levels, and three do the reciprocal divide by 1000 and the
//   clamp.
// Reset:
//   rst_n clears the valid bit of every stage; the pipeline comes up empty.
// Stall:
//   While out_ready is low the output holds; earlier stages keep filling
//   their bubbles, and in_ready drops only once every stage holds a pixel.
// ---------------------------------------------------------------------------
`default_nettype none

module yiq_hue_saturation_value_transform_unit
  import yhsv_pkg::*;
#(
  parameter int HUE_BITS       = HUE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [9:0]  in_hue_turn,
  input  wire logic [8:0]  in_saturation,
  input  wire logic [8:0]  in_brightness,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [7:0]  out_red,
  output logic      [7:0]  out_green,
  output logic      [7:0]  out_blue
);

  localparam int ACW = TRIG_FRAC_BITS + ACC_HEAD;

  logic [PIPE_STAGES-1:0]    vld_r;
  logic [PIPE_STAGES-1:0]    vld_nxt;
  logic [PIPE_STAGES-1:0]    en;
  logic [TRIG_FRAC_BITS:0]   sin_mag;
  logic                      sin_neg;
  logic [TRIG_FRAC_BITS:0]   cos_mag;
  logic                      cos_neg;
  logic signed [ACW-1:0]     acc [3];

  // A stage loads when it is empty or the stage after it moves on.
  always_comb begin
    en[PIPE_STAGES-1] = !vld_r[PIPE_STAGES-1] || out_ready;
    for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  // Valid bits travel with the data.
  always_comb begin
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end else begin
      vld_nxt[0] = vld_r[0];
    end
    for (int i = 1; i < PIPE_STAGES; i++) begin
      if (en[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end else begin
        vld_nxt[i] = vld_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[PIPE_STAGES-1];

  // Sine and cosine lookup, first stage.
  yhsv_trig #(
    .HUE_BITS       (HUE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig (
    .clk       (clk),
    .en        (en[0]),
    .hue_turn  (in_hue_turn),
    .sin_mag_r (sin_mag),
    .sin_neg_r (sin_neg),
    .cos_mag_r (cos_mag),
    .cos_neg_r (cos_neg)
  );

  // Matrix datapath, stages zero to four.
  yhsv_mix #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_mix (
    .clk        (clk),
    .en         (en[MIX_STAGES-1:0]),
    .saturation (in_saturation),
    .brightness (in_brightness),
    .red        (in_red),
    .green      (in_green),
    .blue       (in_blue),
    .sin_mag    (sin_mag),
    .sin_neg    (sin_neg),
    .cos_mag    (cos_mag),
    .cos_neg    (cos_neg),
    .acc_r      (acc)
  );

  // Normalization of each channel, last three stages.
  yhsv_norm #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_norm_red (
    .clk    (clk),
    .en     (en[PIPE_STAGES-1:MIX_STAGES]),
    .acc    (acc[0]),
    .chan_r (out_red)
  );

  yhsv_norm #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_norm_green (
    .clk    (clk),
    .en     (en[PIPE_STAGES-1:MIX_STAGES]),
    .acc    (acc[1]),
    .chan_r (out_green)
  );

  yhsv_norm #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_norm_blue (
    .clk    (clk),
    .en     (en[PIPE_STAGES-1:MIX_STAGES]),
    .acc    (acc[2]),
    .chan_r (out_blue)
  );

endmodule

`default_nettype wire

### rtl/yhsv_checker.sv
// ---------------------------------------------------------------------------
// YIQ hue transform checker
// Port-level assertions on the handshake behavior of the transform unit.
// ---------------------------------------------------------------------------
`default_nettype none

module yhsv_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its pixel.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_red) && $stable(out_green)
                                && $stable(out_blue))
    else $error("result changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // With no result waiting, the pipeline has room.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // When the output drains, every stage can advance.
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input blocked while output drains");

endmodule

bind yiq_hue_saturation_value_transform_unit yhsv_checker u_yhsv_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_red       (out_red),
  .out_green     (out_green),
  .out_blue      (out_blue)
);

`default_nettype wire

### verif/yhsv_pixel_checker.sv
// ---------------------------------------------------------------------------
// YIQ hue/saturation/value pixel checker
// Watches both channels of the transform unit. It predicts every pixel with
// its own fixed-point model of the hue rotation and compares the results.
// ---------------------------------------------------------------------------
module yhsv_pixel_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [9:0] in_hue_turn,
  input  logic [8:0] in_saturation,
  input  logic [8:0] in_brightness,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_red,
  input  logic [7:0] out_green,
  input  logic [7:0] out_blue,
  input  logic       drain_done,
  output int         fail_count,
  output int         pending_count,
  output int         pixels_sent,
  output int         pixels_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HUE_W    = yhsv_pkg::HUE_BITS_DEF;
  localparam int FRAC_W   = yhsv_pkg::TRIG_FRAC_BITS_DEF;
  localparam int HUE_IN_W = yhsv_pkg::HUE_IN_BITS;
  localparam int QTR      = 1 << (HUE_W - 2);
  localparam int LUT_SIZE = 1 << HUE_W;
  localparam int CHAN_TOP = 255;

  // Rotation weights in thousandths, laid out as [channel][source color][V, U, W].
  localparam logic [26:0][11:0] ROT_WEIGHT = {
    12'sd299,  12'sd701,  12'sd168,
    12'sd587, -12'sd587,  12'sd330,
    12'sd114, -12'sd114, -12'sd497,
    12'sd299, -12'sd299, -12'sd328,
    12'sd587,  12'sd413,  12'sd35,
    12'sd114, -12'sd114,  12'sd292,
    12'sd299, -12'sd300,  12'sd1250,
    12'sd587, -12'sd588, -12'sd1050,
    12'sd114,  12'sd886, -12'sd203
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pixel_t;

  longint     sine_lut [LUT_SIZE];
  rgb_pixel_t expected_pixels [$];
  bit         leftover_checked;

  // Sine magnitude in the first quadrant: Taylor series in Q30, rounded.
  function automatic longint first_quadrant_sine(input longint offset);
    longint x;
    longint x_sq;
    longint term;
    longint total;
    x     = (yhsv_pkg::PI_HALF_Q30 * offset) / QTR;
    x_sq  = (x * x) >>> 30;
    term  = x;
    total = x;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x_sq) >>> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        total = total - term;
      end else begin
        total = total + term;
      end
    end
    if (total < 0) begin
      total = 0;
    end
    return (total + (64'sd1 <<< (29 - FRAC_W))) >>> (30 - FRAC_W);
  endfunction

  function automatic longint rot_weight(input int chan, input int src, input int term);
    logic [11:0] raw;
    raw = ROT_WEIGHT[26 - (chan * 9 + src * 3 + term)];
    return longint'($signed(raw));
  endfunction

  // Expected output pixel for one input transaction.
  function automatic rgb_pixel_t rotate_pixel_hue(
    input logic [9:0] hue,
    input logic [8:0] sat,
    input logic [8:0] val,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue
  );
    int unsigned k;
    longint      v_term;
    longint      gain_prod;
    longint      u_term;
    longint      w_term;
    longint      denom;
    longint      acc;
    longint      mix;
    longint      quot;
    longint      level [3];
    logic [7:0]  chan_out [3];
    rgb_pixel_t  px;
    level[0] = longint'(red);
    level[1] = longint'(green);
    level[2] = longint'(blue);
    if (HUE_W >= HUE_IN_W) begin
      k = 32'(hue) << (HUE_W - HUE_IN_W);
    end else begin
      k = 32'(hue) >> (HUE_IN_W - HUE_W);
    end
    v_term    = longint'(val) <<< (8 + FRAC_W);
    gain_prod = longint'(val) * longint'(sat);
    u_term    = gain_prod * sine_lut[(k + QTR) % LUT_SIZE];
    w_term    = gain_prod * sine_lut[k % LUT_SIZE];
    denom     = 64'sd1000 <<< (16 + FRAC_W);
    for (int c = 0; c < 3; c++) begin
      acc = 0;
      for (int s = 0; s < 3; s++) begin
        mix = rot_weight(c, s, 0) * v_term + rot_weight(c, s, 1) * u_term
            + rot_weight(c, s, 2) * w_term;
        acc = acc + mix * level[s];
      end
      // Negative sums clamp to black, large ones to full scale.
      if (acc <= 0) begin
        chan_out[c] = 8'd0;
      end else begin
        quot = acc / denom;
        chan_out[c] = (quot > CHAN_TOP) ? 8'd255 : quot[7:0];
      end
    end
    px.red   = chan_out[0];
    px.green = chan_out[1];
    px.blue  = chan_out[2];
    return px;
  endfunction

  // Build the signed sine table over a full turn.
  initial begin : build_sine_lut
    int quad;
    int offset;
    longint mag;
    for (int k = 0; k < LUT_SIZE; k++) begin
      quad   = k / QTR;
      offset = k % QTR;
      if (quad % 2 == 1) begin
        mag = first_quadrant_sine(QTR - offset);
      end else begin
        mag = first_quadrant_sine(offset);
      end
      sine_lut[k] = (quad >= 2) ? -mag : mag;
    end
  end

  // Compare accepted results first, since they belong to older transactions,
  // then queue the prediction for a newly accepted pixel.
  always @(posedge clk) begin : monitor
    rgb_pixel_t want;
    rgb_pixel_t predicted;
    if (!rst_n) begin
      fail_count       = 0;
      pending_count    = 0;
      pixels_sent      = 0;
      pixels_checked   = 0;
      leftover_checked = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        pixels_checked++;
        if (expected_pixels.size() == 0) begin
          $error("Output transaction with no pixel expected: %0d %0d %0d",
                 out_red, out_green, out_blue);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_red !== want.red) begin
            $error("out_red mismatch: expected %0d, actual %0d", want.red, out_red);
            fail_count++;
          end
          if (out_green !== want.green) begin
            $error("out_green mismatch: expected %0d, actual %0d", want.green, out_green);
            fail_count++;
          end
          if (out_blue !== want.blue) begin
            $error("out_blue mismatch: expected %0d, actual %0d", want.blue, out_blue);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predicted = rotate_pixel_hue(in_hue_turn, in_saturation, in_brightness,
                                     in_red, in_green, in_blue);
        expected_pixels = {expected_pixels, predicted};
        pixels_sent++;
      end
      // Anything still queued once the run has drained never arrived.
      if (drain_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (expected_pixels.size() != 0) begin
          $error("%0d expected pixels never arrived", expected_pixels.size());
          fail_count += expected_pixels.size();
        end
      end
      pending_count = expected_pixels.size();
    end
  end

endmodule

### verif/tb_top.sv
// ---------------------------------------------------------------------------
// Testbench top for the YIQ hue/saturation/value transform unit
// Drives directed and random pixels with random idling on both channels,
// a long output hold-off and drain pauses; the checker does the comparing.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PIXELS  = 950;
  localparam int HOLDOFF_CYCLES = 160;
  localparam int WATCHDOG_LIMIT = 4000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [9:0] in_hue_turn;
  logic [8:0] in_saturation;
  logic [8:0] in_brightness;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       drain_done;

  int fail_count;
  int pending_count;
  int pixels_sent;
  int pixels_checked;
  int holdoff_count;
  bit tx_no_idle;
  bit rx_no_idle;
  bit holdoff_req;

  yiq_hue_saturation_value_transform_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hue_turn   (in_hue_turn),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  yhsv_pixel_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_hue_turn    (in_hue_turn),
    .in_saturation  (in_saturation),
    .in_brightness  (in_brightness),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .drain_done     (drain_done),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .pixels_sent    (pixels_sent),
    .pixels_checked (pixels_checked)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Gains: mostly up to unity, some above it, and the extremes.
  function automatic logic [8:0] draw_gain();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      return 9'($urandom_range(0, 256));
    end else if (pick < 9) begin
      return 9'($urandom_range(257, 511));
    end else begin
      case ($urandom_range(0, 2))
        0:       return 9'd0;
        1:       return 9'd256;
        default: return 9'd511;
      endcase
    end
  endfunction

  // Color levels: mostly uniform, sometimes fully off or fully on.
  function automatic logic [7:0] draw_level();
    if ($urandom_range(0, 4) != 0) begin
      return 8'($urandom_range(0, 255));
    end else begin
      return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
    end
  endfunction

  // Offer one pixel after a random gap and hold it until it is accepted.
  // Called and returning at a falling edge.
  task automatic send_pixel(
    input logic [9:0] hue,
    input logic [8:0] sat,
    input logic [8:0] val,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue
  );
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_hue_turn   <= hue;
    in_saturation <= sat;
    in_brightness <= val;
    in_red        <= red;
    in_green      <= green;
    in_blue       <= blue;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering pixels until every queued result has come back.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  // Result side: random stalls, idle-free stretches and one long hold-off.
  initial begin : result_sink
    int stall;
    int served;
    served        = 0;
    holdoff_count = 0;
    rx_no_idle    = 1'b0;
    out_ready     = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (served % 40 == 0) begin
        rx_no_idle = ($urandom_range(0, 3) == 0);
      end
      if (holdoff_req) begin
        stall       = HOLDOFF_CYCLES;
        holdoff_req = 1'b0;
        holdoff_count++;
      end else begin
        stall = rx_no_idle ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
      served++;
    end
  end

  // End the run when nothing has been accepted for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Watchdog expired with %0d pixels outstanding", pending_count);
    $display("tb_top failed");
    $finish;
  end

  // Stimulus and verdict.
  initial begin : stimulus
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_hue_turn   = '0;
    in_saturation = '0;
    in_brightness = '0;
    in_red        = '0;
    in_green      = '0;
    in_blue       = '0;
    drain_done    = 1'b0;
    tx_no_idle    = 1'b0;
    holdoff_req   = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pixels: identity, black and white, hue quarters, gain
    // extremes above unity, clamping at both ends and truncated fractions.
    send_pixel(10'd0,    9'd256, 9'd256, 8'd0,   8'd0,   8'd0);
    send_pixel(10'd0,    9'd256, 9'd256, 8'd255, 8'd255, 8'd255);
    send_pixel(10'd0,    9'd256, 9'd256, 8'd200, 8'd100, 8'd50);
    send_pixel(10'd1023, 9'd511, 9'd511, 8'd255, 8'd255, 8'd255);
    send_pixel(10'd256,  9'd256, 9'd256, 8'd255, 8'd0,   8'd0);
    send_pixel(10'd512,  9'd256, 9'd256, 8'd255, 8'd0,   8'd0);
    send_pixel(10'd768,  9'd256, 9'd256, 8'd0,   8'd255, 8'd0);
    send_pixel(10'd512,  9'd511, 9'd256, 8'd0,   8'd0,   8'd255);
    send_pixel(10'd0,    9'd0,   9'd256, 8'd255, 8'd0,   8'd0);
    send_pixel(10'd0,    9'd256, 9'd0,   8'd255, 8'd255, 8'd255);
    send_pixel(10'd700,  9'd511, 9'd0,   8'd255, 8'd0,   8'd255);
    send_pixel(10'd1023, 9'd0,   9'd511, 8'd255, 8'd255, 8'd255);
    send_pixel(10'd128,  9'd300, 9'd200, 8'd17,  8'd240, 8'd99);
    send_pixel(10'd640,  9'd256, 9'd511, 8'd255, 8'd128, 8'd0);
    send_pixel(10'd384,  9'd511, 9'd511, 8'd0,   8'd0,   8'd255);
    send_pixel(10'd1,    9'd1,   9'd1,   8'd1,   8'd1,   8'd1);
    send_pixel(10'd896,  9'd128, 9'd384, 8'd255, 8'd255, 8'd0);
    send_pixel(10'd511,  9'd257, 9'd257, 8'd128, 8'd128, 8'd128);
    send_pixel(10'd513,  9'd256, 9'd256, 8'd0,   8'd255, 8'd255);
    send_pixel(10'd255,  9'd511, 9'd128, 8'd90,  8'd0,   8'd200);
    pause_until_drained();

    // Random pixels. The opening stretch runs back to back while the
    // result side holds off, so the pipeline fills and stalls its input.
    holdoff_req = 1'b1;
    tx_no_idle  = 1'b1;
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      if (n == 80) begin
        tx_no_idle = 1'b0;
      end else if (n > 80 && n % 64 == 0) begin
        tx_no_idle = ($urandom_range(0, 2) == 0);
      end
      if (n == RANDOM_PIXELS / 2) begin
        pause_until_drained();
      end
      send_pixel(10'($urandom_range(0, 1023)), draw_gain(), draw_gain(),
                 draw_level(), draw_level(), draw_level());
    end
    pause_until_drained();

    // Let any stray result surface, then check for leftovers.
    repeat (yhsv_pkg::PIPE_STAGES + 4) @(negedge clk);
    drain_done <= 1'b1;
    repeat (2) @(negedge clk);

    $display("Run covered %0d pixels and %0d results, with gains above unity,",
             pixels_sent, pixels_checked);
    $display("clamping at both ends, %0d long output hold-off and drain pauses.",
             holdoff_count);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
